@@ hdl/h264ftc_pkg.sv @@
`timescale 1ns / 1ps
// Shared codes and helpers for the H.264 frame type classifier.
// No dependencies; imported by h264_frame_type_classifier_top.
package h264ftc_pkg;

   typedef logic [1:0] pic_kind_type;

   localparam pic_kind_type TYPE_UNDEF = 2'd0;
   localparam pic_kind_type TYPE_IDR   = 2'd1;
   localparam pic_kind_type TYPE_P     = 2'd2;
   localparam pic_kind_type TYPE_B     = 2'd3;

   localparam logic [23:0] START_CODE   = 24'h000001;
   localparam logic [31:0] WINDOW_RESET = 32'hffff_ffff;

   localparam logic [7:0] HDR_B     = 8'h01;
   localparam logic [7:0] HDR_P_0   = 8'h21;
   localparam logic [7:0] HDR_P_1   = 8'h41;
   localparam logic [7:0] HDR_P_2   = 8'h61;
   localparam logic [7:0] HDR_IDR_0 = 8'h25;
   localparam logic [7:0] HDR_IDR_1 = 8'h45;
   localparam logic [7:0] HDR_IDR_2 = 8'h65;
   localparam logic [7:0] HDR_AUD   = 8'h09;

   localparam logic [2:0] PPT_IDR = 3'd0;
   localparam logic [2:0] PPT_B   = 3'd2;

   function automatic pic_kind_type slice_kind(input logic [7:0] hdr);
      pic_kind_type kind;
      case (hdr) inside
         HDR_B:                           kind = TYPE_B;
         HDR_P_0, HDR_P_1, HDR_P_2:       kind = TYPE_P;
         HDR_IDR_0, HDR_IDR_1, HDR_IDR_2: kind = TYPE_IDR;
         default:                         kind = TYPE_UNDEF;
      endcase
      return kind;
   endfunction

endpackage

@@ hdl/h264_frame_type_classifier_top.sv @@
`timescale 1ns / 1ps
// H.264 Annex B frame type classifier, top level.
// Depends on h264ftc_pkg.

// The block takes one elementary-stream byte per transfer and accepts a byte
// in every cycle while req_ready is high; the result of the byte that settles
// the type is registered in the result register, or in the skid entry while
// that register holds an untaken result. A 32-bit shift window finds 00 00 01
// start codes; the header after one is judged when the next byte arrives. The
// first slice header (B, P or IDR) yields a result at once and the rest of the
// buffer is skipped; otherwise the last byte yields the type taken from an
// access unit delimiter, or undefined. The state clears after every last byte.
// A two-entry output stage (result register plus skid) lets input keep flowing
// while a result waits; req_ready drops only while the skid entry is full.
module h264_frame_type_classifier_top
   import h264ftc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_stream_byte,
   input  logic         req_is_last,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pic_kind_type rsp_pic_kind,
   output logic         rsp_from_delimiter
);

   logic [31:0]  window_ff, window_in;
   pic_kind_type tent_ff, tent_in;
   logic         decided_ff, decided_in;

   logic         rsp_valid_ff, skid_valid_ff;
   pic_kind_type type_ff, skid_type_ff;
   logic         delim_ff, skid_delim_ff;

   logic         accept, pop, push;
   logic         start_seen, slice_hit;
   pic_kind_type kind, tent_upd, res_type;
   logic         res_delim;

   assign req_ready          = !skid_valid_ff;
   assign accept             = req_valid && req_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pic_kind       = type_ff;
   assign rsp_from_delimiter = delim_ff;
   assign pop                = rsp_valid_ff && rsp_ready;

   always_comb begin
      start_seen = !decided_ff && (window_ff[31:8] == START_CODE);
      kind       = slice_kind(window_ff[7:0]);
      slice_hit  = start_seen && (kind != TYPE_UNDEF);
      tent_upd   = tent_ff;
      if (start_seen && window_ff[7:0] == HDR_AUD) begin
         if (req_stream_byte[7:5] == PPT_IDR) begin
            tent_upd = TYPE_IDR;
         end else if (req_stream_byte[7:5] == PPT_B) begin
            tent_upd = TYPE_B;
         end
      end
      if (slice_hit) begin
         res_type  = kind;
         res_delim = 1'b0;
      end else begin
         res_type  = tent_upd;
         res_delim = (tent_upd != TYPE_UNDEF);
      end
      push = accept && !decided_ff && (slice_hit || req_is_last);

      window_in  = window_ff;
      tent_in    = tent_ff;
      decided_in = decided_ff;
      if (accept) begin
         if (req_is_last) begin
            window_in  = WINDOW_RESET;
            tent_in    = TYPE_UNDEF;
            decided_in = 1'b0;
         end else if (!decided_ff) begin
            window_in  = {window_ff[23:0], req_stream_byte};
            tent_in    = tent_upd;
            decided_in = slice_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         tent_ff    <= TYPE_UNDEF;
         decided_ff <= 1'b0;
      end else begin
         window_ff  <= window_in;
         tent_ff    <= tent_in;
         decided_ff <= decided_in;
      end
   end

   // result register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (rsp_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            type_ff  <= skid_type_ff;
            delim_ff <= skid_delim_ff;
         end
      end else if (push) begin
         if (rsp_valid_ff && !pop) begin
            skid_type_ff  <= res_type;
            skid_delim_ff <= res_delim;
         end else begin
            type_ff  <= res_type;
            delim_ff <= res_delim;
         end
      end
   end

endmodule
